>>> src/alfr_pkg.sv
// Shared types, constants and helper functions of the LED frame renderer.
package alfr_pkg;

   localparam int LED_COUNT_DEF  = 64;
   localparam int INDEX_W        = 6;
   localparam int INDEX_SPAN     = 1 << INDEX_W;
   localparam int LEVEL_W        = 8;
   localparam int MODE_W         = 2;
   localparam int TICK_W         = 10;
   localparam int REQ_W          = 2;
   localparam int CSR_INDEX_W    = 3;
   localparam int COLORS         = 3;
   localparam int BITS_PER_PIXEL = COLORS * LEVEL_W;
   localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);
   localparam int PROD_W         = 2 * LEVEL_W;
   localparam int FRAME_W        = 32;
   localparam int BLINK_HALF     = 20;
   localparam int PULSE_PERIOD   = 2 * BLINK_HALF;
   localparam int PULSE_ON       = 30;
   localparam int PHASE_W        = $clog2(PULSE_PERIOD);

   localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST      = LEVEL_W'(255);
   localparam logic [TICK_W-1:0]  ONE_HIGH_TICKS_RST  = TICK_W'(110);
   localparam logic [TICK_W-1:0]  ONE_LOW_TICKS_RST   = TICK_W'(100);
   localparam logic [TICK_W-1:0]  ZERO_HIGH_TICKS_RST = TICK_W'(50);
   localparam logic [TICK_W-1:0]  ZERO_LOW_TICKS_RST  = TICK_W'(150);

   // request codes
   localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd2;

   // display modes
   localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PULSE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BRIGHTNESS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_HIGH_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_LOW_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_HIGH_TICKS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_LOW_TICKS  = 3'd4;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
      logic [MODE_W-1:0]  mode;
   } entry_type;

   // lane 2 green, lane 1 red, lane 0 blue: flattened it is the wire order
   typedef logic [COLORS-1:0][LEVEL_W-1:0] pixel_type;

   typedef struct packed {
      logic [TICK_W-1:0] one_high;
      logic [TICK_W-1:0] one_low;
      logic [TICK_W-1:0] zero_high;
      logic [TICK_W-1:0] zero_low;
   } tick_cfg_type;

   // phase is the frame counter mod 40; blink lit while counter/20 is even
   function automatic logic lamp_lit(input logic [MODE_W-1:0]  mode,
                                     input logic [PHASE_W-1:0] phase);
      logic lit;
      unique case (mode)
         MODE_ON:    lit = 1'b1;
         MODE_BLINK: lit = (phase < PHASE_W'(BLINK_HALF));
         MODE_PULSE: lit = (phase < PHASE_W'(PULSE_ON));
         default:    lit = 1'b0;
      endcase
      return lit;
   endfunction

   // floor(p / 255) for any product of two 8-bit levels
   function automatic logic [LEVEL_W-1:0] div255(input logic [PROD_W-1:0] p);
      logic [PROD_W:0] s;
      s = {1'b0, p} + (PROD_W + 1)'(p >> LEVEL_W) + (PROD_W + 1)'(1);
      return s[LEVEL_W +: LEVEL_W];
   endfunction

endpackage

>>> src/alfr_led_store.sv
// LED entry memory with per-entry valid bits and registered read port.
module alfr_led_store #(
   parameter int DEPTH  = alfr_pkg::LED_COUNT_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  alfr_pkg::entry_type wr_entry,
   input  logic                rd_en,
   input  logic                rd_hit,
   input  logic [ADDR_W-1:0]   rd_addr,
   output alfr_pkg::entry_type rd_entry
);
   import alfr_pkg::*;

   entry_type        mem_ff [DEPTH];
   entry_type        rd_entry_ff;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic             rd_valid_ff, rd_valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (rd_en) begin
         rd_valid_in = rd_hit & valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   // never-written entry reads as zero levels, mode off
   assign rd_entry = rd_valid_ff ? rd_entry_ff : '0;

endmodule

>>> src/alfr_scaler.sv
// Bit-serial brightness scaler for the three color lanes.
module alfr_scaler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  alfr_pkg::pixel_type          levels,
   input  logic [alfr_pkg::LEVEL_W-1:0] brightness,
   output logic                         done,
   output alfr_pkg::pixel_type          word
);
   import alfr_pkg::*;

   localparam int CNT_W = $clog2(LEVEL_W + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [LEVEL_W-1:0]  mult_ff, mult_in;
   pixel_type           level_ff, level_in;
   pixel_type           word_ff, word_in;
   logic [PROD_W-1:0]   acc_ff [COLORS];
   logic [PROD_W-1:0]   acc_in [COLORS];

   // MSB-first shift-add: one brightness bit per cycle, then divide by 255
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mult_in  = mult_ff;
      level_in = level_ff;
      word_in  = word_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(LEVEL_W);
         mult_in  = brightness;
         level_in = levels;
         for (int c = 0; c < COLORS; c++) begin
            acc_in[c] = '0;
         end
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            for (int c = 0; c < COLORS; c++) begin
               acc_in[c] = (acc_ff[c] << 1)
                         + (mult_ff[LEVEL_W-1] ? PROD_W'(level_ff[c]) : '0);
            end
            mult_in = mult_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
         end else begin
            for (int c = 0; c < COLORS; c++) begin
               word_in[c] = div255(acc_ff[c]);
            end
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mult_ff  <= mult_in;
      level_ff <= level_in;
      word_ff  <= word_in;
      acc_ff   <= acc_in;
   end

   assign done = done_ff;
   assign word = word_ff;

endmodule

>>> src/alfr_serializer.sv
// 24-bit output shift register that hands out one data bit per item.
module alfr_serializer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  alfr_pkg::pixel_type         load_word,
   input  logic                        load_last_led,
   input  alfr_pkg::tick_cfg_type      ticks,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_bit_value,
   output logic [alfr_pkg::TICK_W-1:0] rsp_high_width,
   output logic [alfr_pkg::TICK_W-1:0] rsp_low_width,
   output logic                        rsp_pixel_end,
   output logic                        rsp_frame_end,
   output logic                        done
);
   import alfr_pkg::*;

   logic [BITS_PER_PIXEL-1:0] shift_ff, shift_in;
   logic [BIT_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      last_led_ff, last_led_in;
   logic                      accept;
   logic                      last_bit;

   assign accept   = busy_ff & rsp_ready;
   assign last_bit = (cnt_ff == BIT_CNT_W'(BITS_PER_PIXEL - 1));

   always_comb begin
      shift_in    = shift_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      last_led_in = last_led_ff;
      if (load) begin
         shift_in    = load_word;
         cnt_in      = '0;
         busy_in     = 1'b1;
         last_led_in = load_last_led;
      end else if (accept) begin
         if (last_bit) begin
            busy_in = 1'b0;
         end else begin
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff + BIT_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      last_led_ff <= last_led_in;
   end

   assign rsp_valid      = busy_ff;
   assign rsp_bit_value  = shift_ff[BITS_PER_PIXEL-1];
   assign rsp_high_width = rsp_bit_value ? ticks.one_high : ticks.zero_high;
   assign rsp_low_width  = rsp_bit_value ? ticks.one_low : ticks.zero_low;
   assign rsp_pixel_end  = last_bit;
   assign rsp_frame_end  = last_bit & last_led_ff;
   assign done           = accept & last_bit;

endmodule

>>> src/addressable_led_frame_renderer.sv
// Addressable LED frame renderer: entry store, frame timing, scaling, bit serializer.
// Set, start-frame and idle requests produce no items. A pixel request runs a
// store read, the serial scaler (one step per brightness bit, then the divide by
// 255), a load of the 24-bit output shift register, then 24 output items at one per
// cycle while rsp_ready is high. Synchronous reset clears all entries at once.
module addressable_led_frame_renderer #(
   parameter int LED_COUNT = alfr_pkg::LED_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [alfr_pkg::REQ_W-1:0]       req_type,
   input  logic [alfr_pkg::INDEX_W-1:0]     req_led_index,
   input  logic [alfr_pkg::LEVEL_W-1:0]     req_red_in,
   input  logic [alfr_pkg::LEVEL_W-1:0]     req_green_in,
   input  logic [alfr_pkg::LEVEL_W-1:0]     req_blue_in,
   input  logic [alfr_pkg::MODE_W-1:0]      req_entry_mode,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_bit_value,
   output logic [alfr_pkg::TICK_W-1:0]      rsp_high_width,
   output logic [alfr_pkg::TICK_W-1:0]      rsp_low_width,
   output logic                             rsp_pixel_end,
   output logic                             rsp_frame_end,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [alfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [alfr_pkg::TICK_W-1:0]      csr_data
);
   import alfr_pkg::*;

   // entries past the reach of the 6-bit index are never written: keep no storage
   localparam int STORE_DEPTH = (LED_COUNT < INDEX_SPAN) ? LED_COUNT : INDEX_SPAN;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PTR_W       = $clog2(LED_COUNT + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               last_led_ff, last_led_in;

   logic [LEVEL_W-1:0] brightness_ff, brightness_in;
   tick_cfg_type       ticks_ff, ticks_in;

   logic               req_accept;
   logic               csr_accept;
   logic               pixel_avail;

   logic               wr_en;
   entry_type          wr_entry;
   logic               rd_en;
   logic               rd_hit;
   entry_type          rd_entry;

   logic               scl_start;
   pixel_type          scl_levels;
   logic               scl_done;
   pixel_type          scl_word;

   logic               ser_load;
   logic               ser_done;

   // Handshakes: requests only while no pixel is in flight; registers any time.
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_accept  = req_valid & req_ready;
   assign csr_ready   = 1'b1;
   assign csr_accept  = csr_valid & csr_ready;
   assign pixel_avail = (ptr_ff < PTR_W'(LED_COUNT));

   // Set request: drop it when the index is beyond the LED count.
   assign wr_en = req_accept && (req_type == REQ_SET)
                  && (int'(req_led_index) < LED_COUNT);
   always_comb begin
      wr_entry.red   = req_red_in;
      wr_entry.green = req_green_in;
      wr_entry.blue  = req_blue_in;
      wr_entry.mode  = req_entry_mode;
   end

   // Pixel request: read the entry under the pointer; past the store it reads as off.
   assign rd_en  = req_accept && (req_type == REQ_PIXEL) && pixel_avail;
   assign rd_hit = (ptr_ff < PTR_W'(STORE_DEPTH));

   // Unlit entries feed zero levels so the scaler yields an all-zero word.
   always_comb begin
      if (lamp_lit(rd_entry.mode, phase_ff)) begin
         scl_levels[2] = rd_entry.green;
         scl_levels[1] = rd_entry.red;
         scl_levels[0] = rd_entry.blue;
      end else begin
         scl_levels = '0;
      end
   end

   // Sequencer: one item at a time, pixel work runs read, scale, send.
   always_comb begin
      state_in    = state_ff;
      ptr_in      = ptr_ff;
      frame_in    = frame_ff;
      phase_in    = phase_ff;
      last_led_in = last_led_ff;
      scl_start   = 1'b0;
      ser_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_type)
                  REQ_START: begin
                     // advance the frame counter; keep its phase mod 40 in step,
                     // including the wrap of the 32-bit count
                     frame_in = frame_ff + FRAME_W'(1);
                     if ((frame_ff == '1) || (phase_ff == PHASE_W'(PULSE_PERIOD - 1))) begin
                        phase_in = '0;
                     end else begin
                        phase_in = phase_ff + PHASE_W'(1);
                     end
                     ptr_in = '0;
                  end
                  REQ_PIXEL: begin
                     if (pixel_avail) begin
                        last_led_in = (ptr_ff == PTR_W'(LED_COUNT - 1));
                        ptr_in      = ptr_ff + PTR_W'(1);
                        state_in    = ST_READ;
                     end
                  end
                  default: begin
                     // set handled by the store write; unused code does nothing
                  end
               endcase
            end
         end
         ST_READ: begin
            scl_start = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            if (scl_done) begin
               ser_load = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (ser_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Register writes; an index past the list is ignored.
   always_comb begin
      brightness_in = brightness_ff;
      ticks_in      = ticks_ff;
      if (csr_accept) begin
         unique case (csr_index)
            CSR_BRIGHTNESS:      brightness_in      = csr_data[LEVEL_W-1:0];
            CSR_ONE_HIGH_TICKS:  ticks_in.one_high  = csr_data;
            CSR_ONE_LOW_TICKS:   ticks_in.one_low   = csr_data;
            CSR_ZERO_HIGH_TICKS: ticks_in.zero_high = csr_data;
            CSR_ZERO_LOW_TICKS:  ticks_in.zero_low  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         ptr_ff             <= '0;
         frame_ff           <= '0;
         phase_ff           <= '0;
         last_led_ff        <= 1'b0;
         brightness_ff      <= BRIGHTNESS_RST;
         ticks_ff.one_high  <= ONE_HIGH_TICKS_RST;
         ticks_ff.one_low   <= ONE_LOW_TICKS_RST;
         ticks_ff.zero_high <= ZERO_HIGH_TICKS_RST;
         ticks_ff.zero_low  <= ZERO_LOW_TICKS_RST;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         frame_ff      <= frame_in;
         phase_ff      <= phase_in;
         last_led_ff   <= last_led_in;
         brightness_ff <= brightness_in;
         ticks_ff      <= ticks_in;
      end
   end

   alfr_led_store #(
      .DEPTH  (STORE_DEPTH),
      .ADDR_W (STORE_AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (req_led_index[STORE_AW-1:0]),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_hit   (rd_hit),
      .rd_addr  (ptr_ff[STORE_AW-1:0]),
      .rd_entry (rd_entry)
   );

   alfr_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .start      (scl_start),
      .levels     (scl_levels),
      .brightness (brightness_ff),
      .done       (scl_done),
      .word       (scl_word)
   );

   alfr_serializer u_serializer (
      .clock          (clock),
      .reset          (reset),
      .load           (ser_load),
      .load_word      (scl_word),
      .load_last_led  (last_led_ff),
      .ticks          (ticks_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bit_value  (rsp_bit_value),
      .rsp_high_width (rsp_high_width),
      .rsp_low_width  (rsp_low_width),
      .rsp_pixel_end  (rsp_pixel_end),
      .rsp_frame_end  (rsp_frame_end),
      .done           (ser_done)
   );

endmodule

>>> tb/sv/led_stream_checker.sv
// Line-bit predictor and checker for the LED frame renderer, watching all three channels.
module led_stream_checker #(
   parameter int LED_COUNT = alfr_pkg::LED_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [alfr_pkg::REQ_W-1:0]       req_type,
   input  logic [alfr_pkg::INDEX_W-1:0]     req_led_index,
   input  logic [alfr_pkg::LEVEL_W-1:0]     req_red_in,
   input  logic [alfr_pkg::LEVEL_W-1:0]     req_green_in,
   input  logic [alfr_pkg::LEVEL_W-1:0]     req_blue_in,
   input  logic [alfr_pkg::MODE_W-1:0]      req_entry_mode,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic                             rsp_bit_value,
   input  logic [alfr_pkg::TICK_W-1:0]      rsp_high_width,
   input  logic [alfr_pkg::TICK_W-1:0]      rsp_low_width,
   input  logic                             rsp_pixel_end,
   input  logic                             rsp_frame_end,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [alfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [alfr_pkg::TICK_W-1:0]      csr_data,
   output int                               mismatch_count,
   output int                               bits_outstanding,
   output int                               bits_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import alfr_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic              bit_value;
      logic [TICK_W-1:0] high_width;
      logic [TICK_W-1:0] low_width;
      logic              pixel_end;
      logic              frame_end;
   } line_bit_type;

   entry_type          led_store [LED_COUNT];
   logic [FRAME_W-1:0] frame_count;
   int unsigned        next_led;
   logic [LEVEL_W-1:0] brightness;
   tick_cfg_type       ticks;
   line_bit_type       bits_due [$];

   function automatic bit led_shows(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_ON:    return 1'b1;
         MODE_BLINK: return ((frame_count / BLINK_HALF) % 2) == 0;
         MODE_PULSE: return (frame_count % PULSE_PERIOD) < PULSE_ON;
         default:    return 1'b0;
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] scaled(input logic [LEVEL_W-1:0] level);
      int unsigned prod;
      prod = level * brightness;
      return LEVEL_W'(prod / 255);
   endfunction

   // Queue the 24 line bits of the LED under the pointer, green first, MSB first.
   task automatic queue_pixel_bits();
      logic [BITS_PER_PIXEL-1:0] word;
      entry_type                 lamp;
      line_bit_type              lb;
      if (next_led < LED_COUNT) begin
         lamp = led_store[next_led];
         word = '0;
         if (led_shows(lamp.mode))
            word = {scaled(lamp.green), scaled(lamp.red), scaled(lamp.blue)};
         for (int k = BITS_PER_PIXEL - 1; k >= 0; k--) begin
            lb.bit_value  = word[k];
            lb.high_width = word[k] ? ticks.one_high : ticks.zero_high;
            lb.low_width  = word[k] ? ticks.one_low : ticks.zero_low;
            lb.pixel_end  = (k == 0);
            lb.frame_end  = (k == 0) && (next_led == LED_COUNT - 1);
            bits_due.push_back(lb);
         end
         next_led++;
      end
   endtask

   task automatic check_line_bit();
      line_bit_type got;
      line_bit_type want;
      got.bit_value  = rsp_bit_value;
      got.high_width = rsp_high_width;
      got.low_width  = rsp_low_width;
      got.pixel_end  = rsp_pixel_end;
      got.frame_end  = rsp_frame_end;
      bits_checked++;
      if (bits_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected line bit: bit=%0b high=%0d low=%0d pix_end=%0b frm_end=%0b",
                     $realtime, got.bit_value, got.high_width, got.low_width,
                     got.pixel_end, got.frame_end);
      end else begin
         want = bits_due.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: line bit mismatch", $realtime);
               $display("   expected bit=%0b high=%0d low=%0d pix_end=%0b frm_end=%0b",
                        want.bit_value, want.high_width, want.low_width,
                        want.pixel_end, want.frame_end);
               $display("   actual   bit=%0b high=%0d low=%0d pix_end=%0b frm_end=%0b",
                        got.bit_value, got.high_width, got.low_width,
                        got.pixel_end, got.frame_end);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) led_store[i] = '0;
         frame_count     = '0;
         next_led        = 0;
         brightness      = BRIGHTNESS_RST;
         ticks.one_high  = ONE_HIGH_TICKS_RST;
         ticks.one_low   = ONE_LOW_TICKS_RST;
         ticks.zero_high = ZERO_HIGH_TICKS_RST;
         ticks.zero_low  = ZERO_LOW_TICKS_RST;
         bits_due.delete();
         mismatch_count  = 0;
         bits_checked    = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BRIGHTNESS:      brightness = csr_data[LEVEL_W-1:0];
               CSR_ONE_HIGH_TICKS:  ticks.one_high = csr_data;
               CSR_ONE_LOW_TICKS:   ticks.one_low = csr_data;
               CSR_ZERO_HIGH_TICKS: ticks.zero_high = csr_data;
               CSR_ZERO_LOW_TICKS:  ticks.zero_low = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) check_line_bit();
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_SET: begin
                  if (int'(req_led_index) < LED_COUNT) begin
                     led_store[req_led_index].red   = req_red_in;
                     led_store[req_led_index].green = req_green_in;
                     led_store[req_led_index].blue  = req_blue_in;
                     led_store[req_led_index].mode  = req_entry_mode;
                  end
               end
               REQ_START: begin
                  frame_count = frame_count + 1'b1;
                  next_led    = 0;
               end
               REQ_PIXEL: queue_pixel_bits();
               default: ;
            endcase
         end
      end
      bits_outstanding <= bits_due.size();
   end

endmodule

>>> tb/sv/tb_addressable_led_frame_renderer.sv
// Top-level testbench of the LED frame renderer: clock, reset, stimulus and verdict.
module tb_addressable_led_frame_renderer;
   timeunit 1ns;
   timeprecision 1ps;

   import alfr_pkg::*;

   localparam int LED_COUNT       = LED_COUNT_DEF;
   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 11;
   localparam int LIMIT_CYCLES    = 1_000_000;
   localparam int SETTLE_CYCLES   = 48;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 35;
   // the receiver's long hold-off: start after this many line bits, last this long
   localparam int LONG_HOLD_AFTER = 1200;
   localparam int LONG_HOLD       = 400;

   // request code the block does nothing with, and a register index it ignores
   localparam logic [REQ_W-1:0]       REQ_NOP   = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd5;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [REQ_W-1:0]       req_type = REQ_SET;
   logic [INDEX_W-1:0]     req_led_index = '0;
   logic [LEVEL_W-1:0]     req_red_in = '0;
   logic [LEVEL_W-1:0]     req_green_in = '0;
   logic [LEVEL_W-1:0]     req_blue_in = '0;
   logic [MODE_W-1:0]      req_entry_mode = MODE_OFF;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b1;
   logic                   rsp_bit_value;
   logic [TICK_W-1:0]      rsp_high_width;
   logic [TICK_W-1:0]      rsp_low_width;
   logic                   rsp_pixel_end;
   logic                   rsp_frame_end;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BRIGHTNESS;
   logic [TICK_W-1:0]      csr_data = '0;

   int mismatch_count;
   int bits_outstanding;
   int bits_checked;

   // stimulus bookkeeping, read by the summary
   int cycle_count = 0;
   int items_sent  = 0;
   int starts_sent = 0;
   int pixels_sent = 0;
   int sets_sent   = 0;
   int settings_applied = 1;   // reset values count as the first setting

   // idling control: quiet is shared by the sender and the receiver, gap_pct is the sender's
   bit quiet   = 1'b0;
   int gap_pct = 0;

   always #HALF_PERIOD clock = ~clock;

   addressable_led_frame_renderer #(
      .LED_COUNT(LED_COUNT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_led_index  (req_led_index),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .req_entry_mode (req_entry_mode),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bit_value  (rsp_bit_value),
      .rsp_high_width (rsp_high_width),
      .rsp_low_width  (rsp_low_width),
      .rsp_pixel_end  (rsp_pixel_end),
      .rsp_frame_end  (rsp_frame_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   led_stream_checker #(
      .LED_COUNT(LED_COUNT)
   ) stream_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_led_index    (req_led_index),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_entry_mode   (req_entry_mode),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_high_width   (rsp_high_width),
      .rsp_low_width    (rsp_low_width),
      .rsp_pixel_end    (rsp_pixel_end),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .bits_outstanding (bits_outstanding),
      .bits_checked     (bits_checked)
   );

   // Watchdog: abort a hung run well beyond the slowest legal one.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Cycle limit of %0d reached with %0d line bits still outstanding",
                  LIMIT_CYCLES, bits_outstanding);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stall bursts with calm stretches between them, plus one
   // long hold-off so the block backs up and drops req_ready while items keep coming.
   initial begin : result_sink
      int taken;
      int hold;
      int calm_left;
      int stall_pct;
      bit long_done;
      taken     = 0;
      hold      = 0;
      calm_left = 0;
      stall_pct = 0;
      long_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready) taken++;
         // pick a new stall density every so often; zero gives stall-free stretches
         if (calm_left == 0) begin
            calm_left = $urandom_range(50, 300);
            case ($urandom_range(2))
               0:       stall_pct = 0;
               1:       stall_pct = 6;
               default: stall_pct = 25;
            endcase
         end
         calm_left--;
         if (!long_done && taken >= LONG_HOLD_AFTER) begin
            long_done = 1'b1;
            hold      = 0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            if (hold == 0) rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(99) < stall_pct) begin
            hold = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
         end
      end
   end

   // Levels lean toward the extremes so full-scale and dark channels show up often.
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // Offer one item and hold it until the block takes it; maybe idle first.
   task automatic offer(input logic [REQ_W-1:0]   kind,
                        input logic [INDEX_W-1:0] index,
                        input logic [LEVEL_W-1:0] red,
                        input logic [LEVEL_W-1:0] green,
                        input logic [LEVEL_W-1:0] blue,
                        input logic [MODE_W-1:0]  mode);
      if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_led_index  <= index;
      req_red_in     <= red;
      req_green_in   <= green;
      req_blue_in    <= blue;
      req_entry_mode <= mode;
      do @(posedge clock); while (!req_ready);
      case (kind)
         REQ_SET:   sets_sent++;
         REQ_START: starts_sent++;
         REQ_PIXEL: pixels_sent++;
         default: ;
      endcase
      if (kind != REQ_NOP) items_sent++;
   endtask

   // Start, pixel and unused-code items carry random junk in the fields the block ignores.
   task automatic offer_bare(input logic [REQ_W-1:0] kind);
      offer(kind, INDEX_W'($urandom), LEVEL_W'($urandom), LEVEL_W'($urandom),
            LEVEL_W'($urandom), MODE_W'($urandom));
   endtask

   // Entry writes land mostly on the first few LEDs so short frames show them.
   task automatic offer_random_set(input bit anywhere);
      logic [INDEX_W-1:0] index;
      if (anywhere || $urandom_range(3) == 0) index = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
      else index = INDEX_W'($urandom_range(0, 7));
      offer(REQ_SET, index, pick_level(), pick_level(), pick_level(),
            MODE_W'($urandom_range(0, 3)));
   endtask

   // Drop valid, wait until every predicted line bit is out, then let the pipe settle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (bits_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [TICK_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // One register setting per phase: the extremes first, then random ones.
   task automatic apply_settings(input int phase);
      case (phase)
         1: begin
            write_reg(CSR_BRIGHTNESS, TICK_W'(8'hFF));
            write_reg(CSR_ONE_HIGH_TICKS, '1);
            write_reg(CSR_ONE_LOW_TICKS, TICK_W'(1));
            write_reg(CSR_ZERO_HIGH_TICKS, TICK_W'(1));
            write_reg(CSR_ZERO_LOW_TICKS, '1);
            // an index past the register file must change nothing
            write_reg(CSR_SPARE + CSR_INDEX_W'($urandom_range(0, 2)), TICK_W'($urandom));
         end
         2: begin
            write_reg(CSR_BRIGHTNESS, '0);
            write_reg(CSR_ONE_HIGH_TICKS, TICK_W'(1));
            write_reg(CSR_ONE_LOW_TICKS, '1);
            write_reg(CSR_ZERO_HIGH_TICKS, '1);
            write_reg(CSR_ZERO_LOW_TICKS, TICK_W'(1));
         end
         3: begin
            // zero widths pass through untouched
            write_reg(CSR_BRIGHTNESS, TICK_W'(1));
            write_reg(CSR_ONE_HIGH_TICKS, '0);
            write_reg(CSR_ONE_LOW_TICKS, '0);
            write_reg(CSR_ZERO_HIGH_TICKS, '0);
            write_reg(CSR_ZERO_LOW_TICKS, '0);
         end
         default: begin
            // full 10-bit data on brightness too: the upper bits must be dropped
            write_reg(CSR_BRIGHTNESS, TICK_W'($urandom));
            write_reg(CSR_ONE_HIGH_TICKS, TICK_W'($urandom_range(1, 1023)));
            write_reg(CSR_ONE_LOW_TICKS, TICK_W'($urandom_range(1, 1023)));
            write_reg(CSR_ZERO_HIGH_TICKS, TICK_W'($urandom_range(1, 1023)));
            write_reg(CSR_ZERO_LOW_TICKS, TICK_W'($urandom_range(1, 1023)));
         end
      endcase
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // A frame segment: start (sometimes several, sometimes none), a few entry writes,
   // then pixel requests. A sweep walks every LED and may run past the last one.
   task automatic run_segment(input bit sweep);
      int pixels;
      int extra_starts;
      if (sweep || $urandom_range(7) != 0) offer_bare(REQ_START);
      if (!sweep && $urandom_range(2) == 0) begin
         extra_starts = $urandom_range(1, 10);
         repeat (extra_starts) offer_bare(REQ_START);
      end
      repeat ($urandom_range(0, 4)) offer_random_set(1'b0);
      pixels = sweep ? LED_COUNT + $urandom_range(0, 3) : $urandom_range(1, 8);
      repeat (pixels) begin
         if ($urandom_range(7) == 0) offer_random_set(sweep);
         if ($urandom_range(19) == 0) offer_bare(REQ_NOP);
         offer_bare(REQ_PIXEL);
      end
   endtask

   initial begin : stimulus
      int phase_goal;
      bit swept;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset register values.
      gap_pct = 20;
      // pixel before any frame start: LED 0 is still off, counter at zero
      offer(REQ_PIXEL, '0, '0, '0, '0, MODE_OFF);
      offer(REQ_SET, '0, '1, '1, '1, MODE_ON);
      offer(REQ_SET, INDEX_W'(INDEX_SPAN - 1), 8'h00, 8'hFF, 8'h80, MODE_PULSE);
      offer(REQ_SET, INDEX_W'(1), 8'hAA, 8'h55, 8'h01, MODE_BLINK);
      offer(REQ_SET, INDEX_W'(2), 8'h80, 8'h7F, 8'hFE, MODE_OFF);
      offer(REQ_SET, INDEX_W'(3), 8'h01, 8'h00, 8'hFF, MODE_PULSE);
      // unused request code: nothing may come of it
      offer(REQ_NOP, 6'h2A, 8'h5A, 8'hA5, 8'hC3, MODE_ON);
      // pointer sits at LED 1 here: blink, lit at counter zero
      offer_bare(REQ_PIXEL);
      offer_bare(REQ_START);
      repeat (4) offer_bare(REQ_PIXEL);
      offer(REQ_SET, '0, '0, '0, '0, MODE_ON);
      offer_bare(REQ_START);
      offer_bare(REQ_PIXEL);

      // Random part: one register setting per phase, idle before each change.
      for (int phase = 1; phase <= PHASES; phase++) begin
         drain();
         apply_settings(phase);
         quiet = (phase == PHASES);
         case ($urandom_range(2))
            0:       gap_pct = 0;
            1:       gap_pct = 10;
            default: gap_pct = 35;
         endcase
         phase_goal = items_sent + ITEMS_PER_PHASE;
         swept = !(phase == 2 || phase == 5);
         while (items_sent < phase_goal) begin
            run_segment(!swept);
            swept = 1'b1;
            // now and then hold the sender until the block has emptied
            if ($urandom_range(11) == 0) drain();
         end
      end

      drain();
      $display("Sent %0d request items (%0d frame starts, %0d pixel requests, %0d entry writes)",
               items_sent, starts_sent, pixels_sent, sets_sent);
      $display("under %0d register settings; %0d line bits compared, %0d mismatches.",
               settings_applied, bits_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
src/alfr_pkg.sv
src/alfr_led_store.sv
src/alfr_scaler.sv
src/alfr_serializer.sv
src/addressable_led_frame_renderer.sv
tb/sv/led_stream_checker.sv
tb/sv/tb_addressable_led_frame_renderer.sv
